@@ hw/rtl/ccdp_pkg.sv @@
// ccdp_pkg: widths, sequencer types and control structs for the contour
// chord-distance peak detector
// depends on nothing; imported by contour_chord_distance_peaks
package ccdp_pkg;

  localparam int COORD_BITS = 10;

  // signed coordinate difference
  localparam int DIFF_W = COORD_BITS + 1;
  // multiplier operand, also holds |cross| and the squared chord length
  localparam int LEN_W  = 2 * COORD_BITS + 2;
  // squared cross product
  localparam int NUM_W  = 2 * LEN_W - 1;
  localparam int NUMH_W = NUM_W - LEN_W;
  localparam int PROD_W = 2 * LEN_W;
  // signed accumulator: a fraction cross product plus sign
  localparam int ACC_W  = 3 * LEN_W + 1;

  localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  localparam int STEP_W  = 4;
  localparam int N_STEPS = 13;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // micro-op sequence of the shared multiply-accumulate unit
  typedef enum logic [STEP_W-1:0] {
    SP_CROSS_A = 4'd0,   // cx * dy1
    SP_CROSS_B = 4'd1,   // - cy * dx1
    SP_LEN_A   = 4'd2,   // cx * cx
    SP_LEN_B   = 4'd3,   // + cy * cy
    SP_NUM     = 4'd4,   // |cross| * |cross|
    SP_CA0     = 4'd5,   // n1 * den0 ...
    SP_CA1     = 4'd6,
    SP_CA2     = 4'd7,   // ... - n0 * den1
    SP_CA3     = 4'd8,
    SP_CB0     = 4'd9,   // num * den1 ...
    SP_CB1     = 4'd10,
    SP_CB2     = 4'd11,  // ... - n1 * den
    SP_CB3     = 4'd12
  } step_e;

  typedef struct packed {
    logic load;   // start a new sum
    logic neg;    // subtract the product
    logic shift;  // product weighted by 2^LEN_W
  } mac_ctl_t;

endpackage

@@ hw/rtl/contour_chord_distance_peaks.sv @@
// contour_chord_distance_peaks: detects local maxima of the chord distance
// along a contour using one shared multiply-accumulate unit
// depends on ccdp_pkg
//
// channel   dir  fields (lowest bit up)                 accepted when
// s_axis    in   tdata: point_x, point_y; tuser: start   tvalid & tready
// m_axis    out  tdata: key_x, key_y                     tvalid & tready
//
// a point that completes a neighbor triple runs through the multiply-
// accumulate sequence (13 issued products, then the product and accumulate
// stages) and through the emit state when it yields a peak; other points are taken directly.
// the shared multiplier is the limiting resource.
// s_axis_tready is high only while no point is in the sequence.
// a stalled result is held in the output register; a following peak waits.
// reset clears the history: no points held, distances zero.
module contour_chord_distance_peaks
  import ccdp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // point_x, point_y
  input  logic                  s_axis_tuser,   // contour_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // key_x, key_y
);

  state_e state_q, state_d;

  logic [COORD_BITS-1:0] px_q [2];
  logic [COORD_BITS-1:0] py_q [2];
  logic [NUM_W-1:0]      n_q  [2];
  logic [LEN_W-1:0]      d_q  [2];
  logic [1:0]            seen_q;

  logic [COORD_BITS-1:0] nx_q, ny_q;
  logic [COORD_BITS-1:0] key_x_q, key_y_q;
  logic [COORD_BITS-1:0] pk_x_q, pk_y_q;
  logic [STEP_W-1:0]     cyc_q;

  logic [LEN_W-1:0]      mag_q, den_q;
  logic [NUM_W-1:0]      num_q;
  logic                  zero_len_q;
  logic                  gt_a_q;

  // product stage and accumulate stage
  logic [PROD_W-1:0]     prod_q;
  mac_ctl_t              p_ctl_q;
  step_e                 p_step_q, a_step_q;
  logic                  p_vld_q, a_vld_q;
  logic [ACC_W-1:0]      acc_q;

  logic                  in_beat, slot_free, issue_en, finish, hit, le_b;
  step_e                 cur_step;
  mac_ctl_t              cur_ctl;
  logic [LEN_W-1:0]      op_a, op_b;
  logic [COORD_BITS-1:0] in_x, in_y;

  logic signed [DIFF_W-1:0] cx, cy, dx1, dy1;
  logic [DIFF_W-1:0]        cx_m, cy_m, dx1_m, dy1_m;
  logic [ACC_W-1:0]         addend, acc_base, acc_mag;

  function automatic logic [DIFF_W-1:0] abs_d(logic signed [DIFF_W-1:0] v);
    abs_d = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  assign in_x = s_axis_tdata[COORD_BITS-1:0];
  assign in_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = OUT_DATA_W'({key_y_q, key_x_q});

  // chord from the oldest point to the new one, middle point relative to it
  assign cx  = $signed({1'b0, nx_q}) - $signed({1'b0, px_q[0]});
  assign cy  = $signed({1'b0, ny_q}) - $signed({1'b0, py_q[0]});
  assign dx1 = $signed({1'b0, px_q[1]}) - $signed({1'b0, px_q[0]});
  assign dy1 = $signed({1'b0, py_q[1]}) - $signed({1'b0, py_q[0]});
  assign cx_m  = abs_d(cx);
  assign cy_m  = abs_d(cy);
  assign dx1_m = abs_d(dx1);
  assign dy1_m = abs_d(dy1);

  assign issue_en = (state_q == ST_CALC) && (cyc_q < STEP_W'(N_STEPS));
  assign cur_step = step_e'(cyc_q);

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    cur_ctl = '{load: 1'b0, neg: 1'b0, shift: 1'b0};
    case (cur_step)
      SP_CROSS_A: begin
        op_a    = LEN_W'(cx_m);
        op_b    = LEN_W'(dy1_m);
        cur_ctl = '{load: 1'b1, neg: cx[DIFF_W-1] ^ dy1[DIFF_W-1], shift: 1'b0};
      end
      SP_CROSS_B: begin
        op_a    = LEN_W'(cy_m);
        op_b    = LEN_W'(dx1_m);
        cur_ctl = '{load: 1'b0, neg: !(cy[DIFF_W-1] ^ dx1[DIFF_W-1]), shift: 1'b0};
      end
      SP_LEN_A: begin
        op_a    = LEN_W'(cx_m);
        op_b    = LEN_W'(cx_m);
        cur_ctl = '{load: 1'b1, neg: 1'b0, shift: 1'b0};
      end
      SP_LEN_B: begin
        op_a    = LEN_W'(cy_m);
        op_b    = LEN_W'(cy_m);
        cur_ctl = '{load: 1'b0, neg: 1'b0, shift: 1'b0};
      end
      SP_NUM: begin
        op_a    = mag_q;
        op_b    = mag_q;
        cur_ctl = '{load: 1'b1, neg: 1'b0, shift: 1'b0};
      end
      SP_CA0: begin
        op_a    = n_q[1][LEN_W-1:0];
        op_b    = d_q[0];
        cur_ctl = '{load: 1'b1, neg: 1'b0, shift: 1'b0};
      end
      SP_CA1: begin
        op_a    = LEN_W'(n_q[1][NUM_W-1:LEN_W]);
        op_b    = d_q[0];
        cur_ctl = '{load: 1'b0, neg: 1'b0, shift: 1'b1};
      end
      SP_CA2: begin
        op_a    = n_q[0][LEN_W-1:0];
        op_b    = d_q[1];
        cur_ctl = '{load: 1'b0, neg: 1'b1, shift: 1'b0};
      end
      SP_CA3: begin
        op_a    = LEN_W'(n_q[0][NUM_W-1:LEN_W]);
        op_b    = d_q[1];
        cur_ctl = '{load: 1'b0, neg: 1'b1, shift: 1'b1};
      end
      SP_CB0: begin
        op_a    = num_q[LEN_W-1:0];
        op_b    = d_q[1];
        cur_ctl = '{load: 1'b1, neg: 1'b0, shift: 1'b0};
      end
      SP_CB1: begin
        op_a    = LEN_W'(num_q[NUM_W-1:LEN_W]);
        op_b    = d_q[1];
        cur_ctl = '{load: 1'b0, neg: 1'b0, shift: 1'b1};
      end
      SP_CB2: begin
        op_a    = n_q[1][LEN_W-1:0];
        op_b    = den_q;
        cur_ctl = '{load: 1'b0, neg: 1'b1, shift: 1'b0};
      end
      SP_CB3: begin
        op_a    = LEN_W'(n_q[1][NUM_W-1:LEN_W]);
        op_b    = den_q;
        cur_ctl = '{load: 1'b0, neg: 1'b1, shift: 1'b1};
      end
      default: begin
        op_a    = '0;
        op_b    = '0;
        cur_ctl = '{load: 1'b0, neg: 1'b0, shift: 1'b0};
      end
    endcase
  end

  // accumulate: base +/- product, the subtract as invert plus carry-in
  assign addend   = p_ctl_q.shift ? ACC_W'({prod_q, {LEN_W{1'b0}}}) : ACC_W'(prod_q);
  assign acc_base = p_ctl_q.load ? '0 : acc_q;
  assign acc_mag  = acc_q[ACC_W-1] ? (~acc_q + ACC_W'(1)) : acc_q;

  assign le_b   = acc_q[ACC_W-1] || (acc_q == '0);
  assign finish = a_vld_q && (a_step_q == SP_CB3);
  assign hit    = gt_a_q && le_b;

  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      prod_q  <= op_a * op_b;
      p_ctl_q <= cur_ctl;
    end
    if (p_vld_q) begin
      acc_q <= acc_base + (addend ^ {ACC_W{p_ctl_q.neg}}) + ACC_W'(p_ctl_q.neg);
    end
    if (in_beat) begin
      nx_q <= in_x;
      ny_q <= in_y;
    end
    // results are taken from the accumulator in the cycle after their last add
    if (a_vld_q) begin
      case (a_step_q)
        SP_CROSS_B: mag_q <= acc_mag[LEN_W-1:0];
        SP_LEN_B: begin
          zero_len_q <= (acc_q[LEN_W-1:0] == '0);
          den_q      <= (acc_q[LEN_W-1:0] == '0) ? LEN_W'(1) : acc_q[LEN_W-1:0];
        end
        SP_NUM:   num_q  <= zero_len_q ? '0 : acc_q[NUM_W-1:0];
        SP_CA3:   gt_a_q <= !acc_q[ACC_W-1] && (acc_q != '0);
        default: ;
      endcase
    end
    // peak waits here until the output register is free
    if (finish && hit) begin
      pk_x_q <= px_q[0];
      pk_y_q <= py_q[0];
    end
    if (state_q == ST_EMIT && slot_free) begin
      key_x_q <= pk_x_q;
      key_y_q <= pk_y_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_beat && !s_axis_tuser && (seen_q == 2'd2)) state_d = ST_CALC;
      ST_CALC: if (finish) state_d = hit ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      seen_q        <= '0;
      cyc_q         <= '0;
      p_vld_q       <= 1'b0;
      a_vld_q       <= 1'b0;
      p_step_q      <= SP_CROSS_A;
      a_step_q      <= SP_CROSS_A;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        px_q[k] <= '0;
        py_q[k] <= '0;
        n_q[k]  <= '0;
        d_q[k]  <= LEN_W'(1);
      end
    end else begin
      state_q  <= state_d;
      p_vld_q  <= issue_en;
      p_step_q <= cur_step;
      a_vld_q  <= p_vld_q;
      a_step_q <= p_step_q;

      if (issue_en) begin
        cyc_q <= cyc_q + STEP_W'(1);
      end else if (state_q != ST_CALC) begin
        cyc_q <= '0;
      end

      if (in_beat && (s_axis_tuser || (seen_q != 2'd2))) begin
        // contour start clears the history, then takes the point as the first
        if (s_axis_tuser) begin
          px_q[0] <= '0;
          py_q[0] <= '0;
          seen_q  <= 2'd1;
          for (int k = 0; k < 2; k++) begin
            n_q[k] <= '0;
            d_q[k] <= LEN_W'(1);
          end
        end else begin
          px_q[0] <= px_q[1];
          py_q[0] <= py_q[1];
          seen_q  <= seen_q + 2'd1;
        end
        px_q[1] <= in_x;
        py_q[1] <= in_y;
      end

      if (finish) begin
        px_q[0] <= px_q[1];
        py_q[0] <= py_q[1];
        px_q[1] <= nx_q;
        py_q[1] <= ny_q;
        n_q[0]  <= n_q[1];
        d_q[0]  <= d_q[1];
        n_q[1]  <= num_q;
        d_q[1]  <= den_q;
      end

      if (state_q == ST_EMIT && slot_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // a new result beat only comes out of the emit state
  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("result beat raised outside emit");

  // the accumulator pipeline runs only during a sequence
  a_mac_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> (state_q == ST_CALC))
    else $error("accumulate stage busy outside calc");

  // stored distances never get a zero denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_q[0] != '0) && (d_q[1] != '0))
    else $error("zero distance denominator");

  // the point count saturates at two
  a_seen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q == 2'd2) && !in_beat |=> (seen_q == 2'd2))
    else $error("point count dropped without a beat");

endmodule

@@ tb/sv/contour_chord_distance_peaks_tb.sv @@
// contour_chord_distance_peaks_tb: streams contour points into the peak detector and checks
// every emitted peak against a cycle-free model of the chord-distance maxima
// depends on ccdp_pkg and contour_chord_distance_peaks
module contour_chord_distance_peaks_tb;
  import ccdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 5;
  localparam int RANDOM_POINTS  = 1525;
  localparam int SQUEEZE_CYCLES = 500;
  localparam int TAIL_CYCLES    = 40;
  localparam int IDLE_LIMIT     = 5000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     start;
    int     gap;
  } point_beat_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } peak_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // point_x, point_y
  logic                  s_axis_tuser;   // contour_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // key_x, key_y

  contour_chord_distance_peaks u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  point_beat_t points_pending[$];
  peak_t       peaks_due[$];
  int          n_errors = 0;

  // contour history of the predictor
  peak_t        hist_pt[2];
  int           pts_held;
  logic [127:0] dist_num[2];
  logic [127:0] dist_den[2];

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic void forget_contour();
    for (int k = 0; k < 2; k++) begin
      hist_pt[k].x = '0;
      hist_pt[k].y = '0;
      dist_num[k]  = '0;
      dist_den[k]  = 128'd1;
    end
    pts_held = 0;
  endfunction

  // squared chord distance of the middle point as num/den; peak when it rose and then did not
  function automatic void track_point(input point_beat_t p);
    longint       x0, y0, x1, y1, cx, cy, crs, mag, len2;
    logic [127:0] num, den;
    bit           rose, held;
    peak_t        pk;
    if (p.start) forget_contour();
    if (pts_held >= 2) begin
      x0   = longint'(hist_pt[0].x);
      y0   = longint'(hist_pt[0].y);
      x1   = longint'(hist_pt[1].x);
      y1   = longint'(hist_pt[1].y);
      cx   = longint'(p.x) - x0;
      cy   = longint'(p.y) - y0;
      crs  = cx * (y1 - y0) - cy * (x1 - x0);
      mag  = (crs < 0) ? -crs : crs;
      len2 = cx * cx + cy * cy;
      if (len2 == 0) begin
        num = '0;
        den = 128'd1;
      end else begin
        num = 128'(mag) * 128'(mag);
        den = 128'(len2);
      end
      rose = (dist_num[1] * dist_den[0]) > (dist_num[0] * dist_den[1]);
      held = (num * dist_den[1]) <= (dist_num[1] * den);
      if (rose && held) begin
        pk = hist_pt[0];
        peaks_due = {peaks_due, pk};
      end
      dist_num[0] = dist_num[1];
      dist_den[0] = dist_den[1];
      dist_num[1] = num;
      dist_den[1] = den;
    end
    hist_pt[0]   = hist_pt[1];
    hist_pt[1].x = p.x;
    hist_pt[1].y = p.y;
    if (pts_held < 2) pts_held++;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_point(input int x, input int y, input bit start, input bit no_gap);
    point_beat_t p;
    p.x     = coord_t'(x);
    p.y     = coord_t'(y);
    p.start = start;
    p.gap   = no_gap ? 0 : pick_gap();
    points_pending = {points_pending, p};
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // ---------------------------------------------------------------- sender
  point_beat_t cur_point;
  int          send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    bit offering;
    bit nv;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      send_gap = 0;
      forget_contour();
    end else begin
      offering = s_axis_tvalid;
      nv       = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        track_point(cur_point);
        offering = 1'b0;
      end
      if (!offering) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (points_pending.size() > 0) begin
          cur_point = points_pending.pop_front();
          send_gap  = cur_point.gap;
          nv        = 1'b1;
          s_axis_tdata <= {{(IN_DATA_W - 2 * COORD_BITS){1'b0}}, cur_point.y, cur_point.x};
          s_axis_tuser <= cur_point.start;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // -------------------------------------------------------------- receiver
  int peaks_seen = 0;
  int hold_left;
  bit squeeze_done = 1'b0;

  task automatic check_peak(input logic [OUT_DATA_W-1:0] d);
    peak_t want;
    if (peaks_due.size() == 0) begin
      report($sformatf("peak (%0d,%0d) with none expected",
                       d[COORD_BITS-1:0], d[2*COORD_BITS-1:COORD_BITS]));
    end else begin
      want = peaks_due.pop_front();
      if (d[COORD_BITS-1:0] !== want.x)
        report($sformatf("key_x %0d, expected %0d", d[COORD_BITS-1:0], want.x));
      if (d[2*COORD_BITS-1:COORD_BITS] !== want.y)
        report($sformatf("key_y %0d, expected %0d", d[2*COORD_BITS-1:COORD_BITS], want.y));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_peak(m_axis_tdata);
        peaks_seen++;
      end
      // one long hold-off so the result register fills and the input stalls
      if (!squeeze_done && peaks_seen >= 30) begin
        squeeze_done = 1'b1;
        hold_left    = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (peaks_seen >= 150 && peaks_seen < 300) begin
        rdy = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        hold_left = pick_gap();
        rdy       = (hold_left == 0);
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  // -------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("contour_chord_distance_peaks test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  initial begin
    int  n_added;
    int  len, mode, x, y, ax, ay, bx, by;
    bit  burst;
    rst_ni = 1'b0;

    // corners without a start flag; equal distances at the diagonal corners
    add_point(0, 0, 1'b0, 1'b0);
    add_point(1023, 0, 1'b0, 1'b0);
    add_point(1023, 1023, 1'b0, 1'b0);
    add_point(0, 1023, 1'b0, 1'b0);
    // vertical collinear chord, then a zero-length chord
    add_point(512, 512, 1'b1, 1'b0);
    add_point(512, 700, 1'b0, 1'b0);
    add_point(512, 1023, 1'b0, 1'b0);
    add_point(0, 1023, 1'b0, 1'b0);
    add_point(512, 1023, 1'b0, 1'b0);
    // repeated point: zero distances while it repeats, then a nonzero one
    add_point(1, 1, 1'b1, 1'b0);
    add_point(1, 1, 1'b0, 1'b0);
    add_point(1, 1, 1'b0, 1'b0);
    add_point(1022, 1, 1'b0, 1'b0);
    add_point(0, 1022, 1'b0, 1'b0);
    // rising distance cut off by a new contour
    add_point(0, 0, 1'b1, 1'b0);
    add_point(500, 10, 1'b0, 1'b0);
    add_point(1000, 0, 1'b0, 1'b0);
    add_point(600, 600, 1'b1, 1'b0);
    add_point(341, 682, 1'b0, 1'b0);
    add_point(682, 341, 1'b0, 1'b0);
    add_point(1023, 1023, 1'b0, 1'b0);
    add_point(0, 0, 1'b0, 1'b0);
    add_point(1023, 1, 1'b0, 1'b0);

    n_added = 0;
    while (n_added < RANDOM_POINTS) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      mode  = $urandom_range(0, 99);
      burst = ($urandom_range(0, 4) == 0);
      x     = $urandom_range(0, 1023);
      y     = $urandom_range(0, 1023);
      ax    = $urandom_range(0, 1023);
      ay    = $urandom_range(0, 1023);
      bx    = $urandom_range(0, 1023);
      by    = $urandom_range(0, 1023);
      for (int i = 0; i < len; i++) begin
        if (mode < 60) begin
          // traced outline: small steps
          x = clamp_coord(x + $urandom_range(0, 16) - 8);
          y = clamp_coord(y + $urandom_range(0, 16) - 8);
        end else if (mode < 85) begin
          x = $urandom_range(0, 1023);
          y = $urandom_range(0, 1023);
        end else if (mode < 95) begin
          x = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : 1023 * $urandom_range(0, 1);
          y = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023) : 1023 * $urandom_range(0, 1);
        end else begin
          // back and forth between two points: zero-length chords
          x = (i % 2 == 0) ? ax : bx;
          y = (i % 2 == 0) ? ay : by;
        end
        // a few contours run on without a start flag, a few restart midway
        add_point(x, y, (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0),
                  burst);
        n_added++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (points_pending.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (peaks_due.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (peaks_due.size() != 0) report($sformatf("%0d peaks never came", peaks_due.size()));
    if (n_errors == 0) begin
      $display("contour_chord_distance_peaks test passed");
    end else begin
      $display("contour_chord_distance_peaks test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ccdp_pkg.sv
hw/rtl/contour_chord_distance_peaks.sv
tb/sv/contour_chord_distance_peaks_tb.sv
